// File: hdl/dvo_pkg.sv
// Shared types, constants and table functions for the drum voice oscillator.
// No dependencies; every other file in hdl/ except dvo_stream_if imports this package.
package dvo_pkg;

   localparam int SINE_TABLE_ENTRIES = 257;
   localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES - 1);
   localparam int QUARTER_IDX_W      = SINE_IDX_W - 1;

   localparam int INC_W     = 28;
   localparam int DECAY_W   = 31;
   localparam int DEPTH_W   = 10;
   localparam int PHASE_W   = 31;
   localparam int LEVEL_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic signed [LEVEL_W-1:0] ENV_FLOOR = 32'sh0000_ffff;
   localparam logic [15:0] DEPTH_CENTER = 16'h0200;
   localparam logic [15:0] WEIGHT_FULL  = 16'hffff;
   localparam logic [16:0] TRI_HALF     = 17'h10000;
   localparam logic [15:0] SQUARE_HIGH  = 16'h7fff;
   localparam logic [15:0] SQUARE_LOW   = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP   = 3'd0,
      CSR_DECAY_STEP   = 3'd1,
      CSR_WAVE_SHAPE   = 3'd2,
      CSR_FIFTH_ENABLE = 3'd3,
      CSR_PITCH_DEPTH  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_TRIANGLE = 2'd1,
      SHAPE_SAW      = 2'd2,
      SHAPE_SQUARE   = 2'd3
   } wave_shape_type;

   typedef struct packed {
      logic        action;
      logic [14:0] note_level;
   } req_payload_type;

   typedef struct packed {
      logic [14:0]        envelope_sample;
      logic signed [15:0] wave_sample;
   } rsp_payload_type;

   // Controller to datapath: one step strobe per state, with use_fifth added in the fifth's sine states.
   typedef struct packed {
      logic take;
      logic square;
      logic modulate;
      logic scale_step;
      logic phase;
      logic advance_fifth;
      logic sin_lo;
      logic sin_hi;
      logic use_fifth;
      logic load_out;
   } dvo_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic action;
      logic sine_shape;
      logic fifth_on;
      logic out_busy;
   } dvo_status_type;

   localparam logic [14:0] QUARTER_SINE [0:64] = '{
      15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
      15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
      15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
      15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
      15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
      15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
      15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
      15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
      15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
      15'd32757, 15'd32767
   };

   // Full-cycle sine from the quarter table; the entry past the end wraps to zero.
   function automatic logic signed [15:0] sine_at(input logic [SINE_IDX_W-1:0] idx);
      logic [QUARTER_IDX_W-1:0] j;
      logic [14:0]              mag;
      j = idx[QUARTER_IDX_W-1:0];
      if (j <= 7'd64) begin
         mag = QUARTER_SINE[j];
      end else begin
         mag = QUARTER_SINE[QUARTER_IDX_W'(8'd128 - {1'b0, j})];
      end
      if (idx[SINE_IDX_W-1]) begin
         sine_at = -$signed({1'b0, mag});
      end else begin
         sine_at = $signed({1'b0, mag});
      end
   endfunction

   // Modulation gain: (d-512)*12 below center, (d-512)*48 at or above.
   function automatic logic signed [15:0] depth_gain(input logic [DEPTH_W-1:0] depth);
      logic signed [15:0] diff;
      diff = $signed({6'd0, depth} - DEPTH_CENTER);
      if (!depth[DEPTH_W-1]) begin
         depth_gain = (diff <<< 3) + (diff <<< 2);
      end else begin
         depth_gain = (diff <<< 5) + (diff <<< 4);
      end
   endfunction

endpackage

// File: hdl/dvo_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
// The payload type comes from dvo_pkg at the point of instantiation.
interface dvo_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/dvo_ctrl.sv
// Sequencer for the drum voice: one-hot state machine issuing datapath steps.
// Depends on dvo_pkg for the command and status structs.
module dvo_ctrl
   import dvo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  dvo_status_type status,
   output dvo_cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_SQUARE  = 11'b000_0000_0010,
      ST_MOD     = 11'b000_0000_0100,
      ST_SCALE   = 11'b000_0000_1000,
      ST_PHASE   = 11'b000_0001_0000,
      ST_FIFTH   = 11'b000_0010_0000,
      ST_SIN_LO  = 11'b000_0100_0000,
      ST_SIN_HI  = 11'b000_1000_0000,
      ST_SIN5_LO = 11'b001_0000_0000,
      ST_SIN5_HI = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               // a note-on finishes in the accept cycle
               if (!status.action) state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_MOD;
         end
         ST_MOD: begin
            cmd.modulate = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_step = 1'b1;
            state_in       = ST_PHASE;
         end
         ST_PHASE: begin
            cmd.phase = 1'b1;
            state_in  = ST_FIFTH;
         end
         ST_FIFTH: begin
            cmd.advance_fifth = 1'b1;
            state_in = status.sine_shape ? ST_SIN_LO : ST_DONE;
         end
         ST_SIN_LO: begin
            cmd.sin_lo = 1'b1;
            state_in   = ST_SIN_HI;
         end
         ST_SIN_HI: begin
            cmd.sin_hi = 1'b1;
            state_in   = status.fifth_on ? ST_SIN5_LO : ST_DONE;
         end
         ST_SIN5_LO: begin
            cmd.sin_lo    = 1'b1;
            cmd.use_fifth = 1'b1;
            state_in      = ST_SIN5_HI;
         end
         ST_SIN5_HI: begin
            cmd.sin_hi    = 1'b1;
            cmd.use_fifth = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/dvo_datapath.sv
// Datapath of the drum voice: settings, envelope, phases, shared multiplier,
// wave shaping and the output register. Depends on dvo_pkg.
module dvo_datapath
   import dvo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  req_payload_type       req_payload,
   input  dvo_cmd_type           cmd,
   output dvo_status_type        status,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   input  logic                  rsp_ready
);

   // settings
   logic [INC_W-1:0]   phase_step_ff, phase_step_in;
   logic [DECAY_W-1:0] decay_step_ff, decay_step_in;
   wave_shape_type     wave_shape_ff, wave_shape_in;
   logic               fifth_enable_ff, fifth_enable_in;
   logic [DEPTH_W-1:0] pitch_depth_ff, pitch_depth_in;

   // voice state
   logic [LEVEL_W-1:0] env_level_ff, env_level_in;
   logic [LEVEL_W-1:0] env_square_ff, env_square_in;
   logic [PHASE_W-1:0] main_phase_ff, main_phase_in;
   logic [PHASE_W-1:0] fifth_phase_ff, fifth_phase_in;
   logic               active_ff, active_in;

   // working registers
   logic [14:0]        env_out_ff, env_out_in;
   logic signed [15:0] gain_ff, gain_in;
   logic signed [15:0] b2_ff, b2_in;
   logic [31:0]        mod2_ff, mod2_in;
   logic signed [15:0] sine_ff, sine_in;
   logic signed [32:0] acc_ff, acc_in;
   logic signed [16:0] tone1_ff, tone1_in;
   logic [15:0]        wave_ff, wave_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [48:0] product;

   logic [PHASE_W-1:0]    osc_phase;
   logic [15:0]           scale;
   logic [15:0]           weight;
   logic [SINE_IDX_W-1:0] sine_idx;
   logic signed [32:0]    sin_sum;
   logic signed [16:0]    tone_now;
   logic signed [17:0]    tone_pair;
   logic [16:0]           tri_t;
   logic [16:0]           tri_val;
   logic [15:0]           shape_tone;

   assign osc_phase = cmd.use_fifth ? fifth_phase_ff : main_phase_ff;
   assign scale     = osc_phase[22:7];
   assign weight    = cmd.sin_hi ? scale : WEIGHT_FULL - scale;

   always_comb begin
      if (cmd.square) begin
         mul_a = {{16{env_level_ff[31]}}, env_level_ff[31:16]};
         mul_b = {env_level_ff[31], env_level_ff[31:16]};
      end else if (cmd.modulate) begin
         mul_a = $signed(env_square_ff);
         mul_b = {gain_ff[15], gain_ff};
      end else if (cmd.scale_step) begin
         mul_a = $signed({1'b0, phase_step_ff, 3'b000});
         mul_b = {b2_ff[15], b2_ff};
      end else begin
         mul_a = {{16{sine_ff[15]}}, sine_ff};
         mul_b = $signed({1'b0, weight});
      end
   end

   assign product = mul_a * mul_b;

   // table address for the next interpolation product
   always_comb begin
      if (cmd.sin_lo) begin
         sine_idx = osc_phase[30:23] + 8'd1;
      end else if (cmd.sin_hi) begin
         sine_idx = fifth_phase_ff[30:23];
      end else begin
         sine_idx = main_phase_ff[30:23];
      end
   end

   assign sin_sum   = acc_ff + product[32:0];
   assign tone_now  = sin_sum[32:16];
   assign tone_pair = {tone1_ff[16], tone1_ff} + {tone_now[16], tone_now};

   // non-sine shapes from the new main phase
   assign tri_t = main_phase_ff[30:14];
   always_comb begin
      case (main_phase_ff[30:29])
         2'd1:    tri_val = TRI_HALF - tri_t;
         2'd2:    tri_val = -tri_t;
         default: tri_val = tri_t;
      endcase
   end

   always_comb begin
      case (wave_shape_ff)
         SHAPE_TRIANGLE: shape_tone = tri_val[15:0];
         SHAPE_SAW:      shape_tone = main_phase_ff[30:15];
         SHAPE_SQUARE:   shape_tone = main_phase_ff[30] ? SQUARE_HIGH : SQUARE_LOW;
         default:        shape_tone = '0;
      endcase
   end

   always_comb begin
      phase_step_in   = phase_step_ff;
      decay_step_in   = decay_step_ff;
      wave_shape_in   = wave_shape_ff;
      fifth_enable_in = fifth_enable_ff;
      pitch_depth_in  = pitch_depth_ff;
      env_level_in    = env_level_ff;
      env_square_in   = env_square_ff;
      main_phase_in   = main_phase_ff;
      fifth_phase_in  = fifth_phase_ff;
      active_in       = active_ff;
      env_out_in      = env_out_ff;
      gain_in         = depth_gain(pitch_depth_ff);
      b2_in           = b2_ff;
      mod2_in         = mod2_ff;
      sine_in         = sine_at(sine_idx);
      acc_in          = acc_ff;
      tone1_in        = tone1_ff;
      wave_in         = wave_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP:   phase_step_in   = csr_wr_data[INC_W-1:0];
            CSR_DECAY_STEP:   decay_step_in   = csr_wr_data[DECAY_W-1:0];
            CSR_WAVE_SHAPE:   wave_shape_in   = wave_shape_type'(csr_wr_data[1:0]);
            CSR_FIFTH_ENABLE: fifth_enable_in = csr_wr_data[0];
            CSR_PITCH_DEPTH:  pitch_depth_in  = csr_wr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end

      if (cmd.take) begin
         if (req_payload.action) begin
            env_level_in   = {1'b0, req_payload.note_level, 16'h0000};
            main_phase_in  = '0;
            fifth_phase_in = '0;
         end else begin
            // decay only while the level is at or above the floor
            active_in = $signed(env_level_ff) >= ENV_FLOOR;
            if ($signed(env_level_ff) >= ENV_FLOOR) begin
               env_level_in = env_level_ff - {1'b0, decay_step_ff};
            end
         end
      end

      if (cmd.square) begin
         if (active_ff) begin
            env_square_in = product[31:0];
            env_out_in    = product[29:15];
         end else begin
            env_out_in = '0;
         end
      end

      if (cmd.modulate)   b2_in   = product[45:30];
      if (cmd.scale_step) mod2_in = product[47:16];

      if (cmd.phase) begin
         main_phase_in = main_phase_ff + {3'b000, phase_step_ff} + mod2_ff[30:0];
      end

      if (cmd.advance_fifth) begin
         wave_in = shape_tone;
         if (fifth_enable_ff) begin
            fifth_phase_in = fifth_phase_ff + {3'b000, phase_step_ff}
                           + {4'b0000, phase_step_ff[INC_W-1:1]}
                           + mod2_ff[30:0] + mod2_ff[31:1];
         end
      end

      if (cmd.sin_lo) acc_in = product[32:0];

      if (cmd.sin_hi) begin
         if (cmd.use_fifth) begin
            wave_in = tone_pair[16:1];
         end else begin
            tone1_in = tone_now;
            wave_in  = tone_now[15:0];
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in                   = 1'b1;
         rsp_payload_in.envelope_sample = env_out_ff;
         rsp_payload_in.wave_sample     = $signed(wave_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         decay_step_ff   <= '0;
         wave_shape_ff   <= SHAPE_SINE;
         fifth_enable_ff <= 1'b0;
         pitch_depth_ff  <= DEPTH_CENTER[DEPTH_W-1:0];
         env_level_ff    <= '0;
         env_square_ff   <= '0;
         main_phase_ff   <= '0;
         fifth_phase_ff  <= '0;
         active_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_step_ff   <= phase_step_in;
         decay_step_ff   <= decay_step_in;
         wave_shape_ff   <= wave_shape_in;
         fifth_enable_ff <= fifth_enable_in;
         pitch_depth_ff  <= pitch_depth_in;
         env_level_ff    <= env_level_in;
         env_square_ff   <= env_square_in;
         main_phase_ff   <= main_phase_in;
         fifth_phase_ff  <= fifth_phase_in;
         active_ff       <= active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      env_out_ff     <= env_out_in;
      gain_ff        <= gain_in;
      b2_ff          <= b2_in;
      mod2_ff        <= mod2_in;
      sine_ff        <= sine_in;
      acc_ff         <= acc_in;
      tone1_ff       <= tone1_in;
      wave_ff        <= wave_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.action     = req_payload.action;
   assign status.sine_shape = wave_shape_ff == SHAPE_SINE;
   assign status.fifth_on   = fifth_enable_ff;
   assign status.out_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hdl/drum_voice_oscillator.sv
// Top level of the drum voice: decaying envelope plus modulated oscillator.
// Depends on dvo_pkg, dvo_stream_if, dvo_ctrl and dvo_datapath.
//
//   channel  | direction | beat contents                          | handshake
//   ---------+-----------+----------------------------------------+-------------
//   req_if   | in        | action, note_level                     | valid/ready
//   rsp_if   | out       | envelope_sample, wave_sample           | valid/ready
//   csr_*    | in        | csr_index, csr_wr_data (write only)    | csr_wr_en
//
// A note-on beat is absorbed in its accept cycle and yields no result beat.
// A tick beat holds the sequencer through the square, modulate, scale, phase and
// fifth steps, then the low and high interpolation steps for sine, and those
// steps once more on the fifth phase when the fifth is enabled; its result beat
// is loaded in the done step. One 32x17 multiplier is shared by the envelope
// square, the modulation, the scaled step and every interpolation product.
// New beats are taken only between items; a finished result waits in the
// output register while the next item runs, and the sequencer stalls in its
// last step only if the previous beat is still unclaimed.
// Reset is synchronous: settings return to defaults (depth 512) and the
// envelope and both phases clear.
module drum_voice_oscillator
   import dvo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dvo_stream_if.sink            req_if,
   dvo_stream_if.source          rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   dvo_cmd_type     cmd;
   dvo_status_type  status;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   req_payload_type req_payload;

   assign req_payload = req_if.payload;

   // sequencer: owns the input handshake and the step order
   dvo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: settings, voice state, multiplier and output register
   dvo_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_if.ready)
   );

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;

   // a tick beat holds off the next input until its work is done
   a_tick_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && !req_if.payload.action) |=> !req_if.ready)
      else $error("input taken while a tick is in progress");

   // a note-on completes in its accept cycle
   a_note_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.payload.action) |=> req_if.ready)
      else $error("note-on did not return to idle");

   // never overwrite a result beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_if.valid && !rsp_if.ready))
      else $error("result register loaded while occupied");

   // a result beat appears only from a sequencer load
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.load_out))
      else $error("result valid rose without a load");

endmodule

// File: dv/tb.sv
// Self-checking testbench for drum_voice_oscillator: predicts every output beat
// from the settings and the accepted request beats. Depends on dvo_pkg,
// dvo_stream_if and the drum_voice_oscillator RTL.
module tb;
   import dvo_pkg::*;

   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_NOTE_ON = 1'b1;

   localparam int SETTLE_CYCLES = 16;    // margin for the longest tick, sine with the fifth
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_BEATS  = 840;

   // Quarter wave of a 256-step sine, amplitude 32767.
   localparam int QUARTER_WAVE [0:64] = '{
      0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179, 7962, 8739,
      9512, 10278, 11039, 11793, 12539, 13279, 14010, 14732, 15446, 16151,
      16846, 17530, 18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
      23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790, 27245, 27683,
      28105, 28510, 28898, 29268, 29621, 29956, 30273, 30571, 30852, 31113,
      31356, 31580, 31785, 31971, 32137, 32285, 32412, 32521, 32609, 32678,
      32728, 32757, 32767
   };

   typedef struct packed {
      logic [INC_W-1:0]   phase_inc;
      logic [DECAY_W-1:0] decay;
      wave_shape_type     shape;
      logic               fifth;
      logic [DEPTH_W-1:0] depth;
   } voice_settings_type;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_SPARSE,
      DRAIN_RHYTHM
   } drain_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   dvo_stream_if #(.payload_type(req_payload_type)) req_if ();
   dvo_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   drum_voice_oscillator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted voice: settings and state as the block should hold them.
   logic [INC_W-1:0]   cfg_phase_inc;
   logic [DECAY_W-1:0] cfg_decay;
   wave_shape_type     cfg_shape;
   logic               cfg_fifth;
   logic [DEPTH_W-1:0] cfg_depth;
   logic [31:0]        env_level;
   logic [31:0]        env_square;
   logic [PHASE_W-1:0] main_phase;
   logic [PHASE_W-1:0] fifth_phase;

   rsp_payload_type expected_samples [$];

   int unsigned beats_sent;
   int unsigned note_ons;
   int unsigned samples_seen;
   int unsigned settings_applied;
   int unsigned mismatches;
   int unsigned burst_left;

   // Receiver control: a requested hold-off is counted down here.
   int unsigned    stall_request;
   int unsigned    stall_left;
   int unsigned    drain_left;
   drain_mode_type drain_mode;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("drum_voice_oscillator: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int sine_entry(input int unsigned idx);
      int unsigned j;
      int          mag;
      if (idx >= 256) begin
         idx = 0;
      end
      j = idx & 'h7f;
      mag = (j <= 64) ? QUARTER_WAVE[j] : QUARTER_WAVE[128 - j];
      return (idx & 'h80) ? -mag : mag;
   endfunction

   // Linear interpolation between neighboring table entries.
   function automatic longint sine_tone(input logic [PHASE_W-1:0] ph);
      int unsigned idx;
      longint      weight;
      longint      acc;
      idx = ph[30:23];
      weight = longint'(ph[22:7]);
      acc = longint'(sine_entry(idx)) * (64'sd65535 - weight)
          + longint'(sine_entry(idx + 1)) * weight;
      return acc >>> 16;
   endfunction

   // Advance the voice by one request beat; return 1 when it yields an output beat.
   function automatic bit advance_voice(input logic action, input logic [14:0] level,
                                        output rsp_payload_type result_beat);
      longint             lin;
      longint             top_half;
      longint             square_val;
      longint             gain;
      longint             bend;
      longint             bend_half;
      longint             inc_x8;
      longint             tone;
      logic signed [15:0] half16;
      logic signed [31:0] inc_bend;
      logic signed [31:0] inc_bend_half;
      logic [PHASE_W-1:0] ph;
      logic [16:0]        tri_pos;
      logic [14:0]        env_out;
      result_beat = '0;
      if (action == ACTION_NOTE_ON) begin
         env_level = {1'b0, level, 16'h0000};
         main_phase = '0;
         fifth_phase = '0;
         return 1'b0;
      end

      // Envelope: fall while the level is at least the floor, else hold the square.
      env_out = '0;
      lin = longint'($signed(env_level));
      if (lin >= 64'sd65535) begin
         lin = lin - longint'(cfg_decay);
         env_level = lin[31:0];
         top_half = longint'($signed(env_level[31:16]));
         square_val = top_half * top_half;
         env_square = square_val[31:0];
         env_out = square_val[29:15];
      end

      // Pitch bend from the held square; 512 is the neutral depth.
      if (cfg_depth < 10'd512) begin
         gain = -(((64'sd512 - longint'(cfg_depth)) * 64'sh3000) >>> 9);
      end else begin
         gain = ((longint'(cfg_depth) - 64'sd512) * 64'shc000) >>> 9;
      end
      half16 = 16'(gain >>> 1);
      gain = half16;
      bend = (longint'($signed(env_square)) * gain) >>> 29;
      half16 = 16'(bend >>> 1);
      bend_half = half16;
      inc_x8 = longint'(cfg_phase_inc) << 3;
      inc_bend = 32'((inc_x8 * bend_half) >>> 16);
      inc_bend_half = inc_bend >>> 1;

      ph = main_phase + 31'(cfg_phase_inc) + inc_bend[30:0];
      main_phase = ph;
      if (cfg_fifth) begin
         fifth_phase = fifth_phase + 31'(cfg_phase_inc) + 31'(cfg_phase_inc >> 1)
                     + inc_bend[30:0] + inc_bend_half[30:0];
      end

      case (cfg_shape)
         SHAPE_SINE: begin
            tone = sine_tone(ph);
            if (cfg_fifth) begin
               tone = (tone + sine_tone(fifth_phase)) >>> 1;
            end
         end
         SHAPE_TRIANGLE: begin
            tri_pos = ph[30:14];
            case (ph[30:29])
               2'd1:    tone = 64'sh10000 - longint'(tri_pos);
               2'd2:    tone = -longint'(tri_pos);
               default: tone = longint'(tri_pos);
            endcase
         end
         SHAPE_SAW: begin
            tone = longint'(ph[30:15]);
         end
         default: begin
            tone = ph[30] ? longint'(SQUARE_HIGH) : longint'(SQUARE_LOW);
         end
      endcase

      result_beat.envelope_sample = env_out;
      result_beat.wave_sample = tone[15:0];
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one request beat and hold it until accepted; predict on accept.
   task automatic send_beat(input logic action, input logic [14:0] level);
      req_payload_type beat;
      rsp_payload_type result_beat;
      beat.action = action;
      beat.note_level = level;
      req_if.valid <= 1'b1;
      req_if.payload <= beat;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
      if (action == ACTION_NOTE_ON) begin
         note_ons++;
      end
      if (advance_voice(action, level, result_beat)) begin
         expected_samples.push_back(result_beat);
      end
   endtask

   // Bursts of random length, then a random gap with valid dropped.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Drop valid, wait for every predicted beat, then let any note-on settle.
   task automatic wait_for_samples();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(posedge clock);
      case (index)
         CSR_PHASE_STEP:   cfg_phase_inc = data[INC_W-1:0];
         CSR_DECAY_STEP:   cfg_decay = data[DECAY_W-1:0];
         CSR_WAVE_SHAPE:   cfg_shape = wave_shape_type'(data[1:0]);
         CSR_FIFTH_ENABLE: cfg_fifth = data[0];
         CSR_PITCH_DEPTH:  cfg_depth = data[DEPTH_W-1:0];
         default: ;        // unlisted index: no register changes
      endcase
   endtask

   task automatic close_csr();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input voice_settings_type s);
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'(s.phase_inc));
      write_csr(CSR_DECAY_STEP, CSR_DATA_W'(s.decay));
      write_csr(CSR_WAVE_SHAPE, CSR_DATA_W'(s.shape));
      write_csr(CSR_FIFTH_ENABLE, CSR_DATA_W'(s.fifth));
      write_csr(CSR_PITCH_DEPTH, CSR_DATA_W'(s.depth));
      close_csr();
      settings_applied++;
   endtask

   function automatic voice_settings_type random_settings();
      voice_settings_type s;
      case ($urandom_range(0, 5))
         0:       s.phase_inc = '0;
         1:       s.phase_inc = '1;
         2, 3:    s.phase_inc = INC_W'($urandom);
         default: s.phase_inc = INC_W'($urandom_range(1, 1 << 22));
      endcase
      case ($urandom_range(0, 7))
         0:       s.decay = '0;
         1:       s.decay = '1;
         2:       s.decay = DECAY_W'($urandom);
         default: s.decay = DECAY_W'($urandom_range(1 << 14, 1 << 25));
      endcase
      s.shape = wave_shape_type'($urandom_range(0, 3));
      s.fifth = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 6))
         0:       s.depth = '0;
         1:       s.depth = '1;
         2:       s.depth = 10'd512;
         3:       s.depth = DEPTH_W'($urandom_range(510, 514));
         default: s.depth = DEPTH_W'($urandom);
      endcase
      return s;
   endfunction

   // One note: a note-on and a run of ticks carrying junk in the ignored level.
   task automatic play_voice(input bit paced);
      logic [14:0] level;
      int unsigned ticks;
      case ($urandom_range(0, 5))
         0:       level = 15'h7fff;
         1:       level = 15'($urandom_range(0, 1));
         default: level = 15'($urandom);
      endcase
      ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
      send_beat(ACTION_NOTE_ON, level);
      if (paced) pace_sender();
      repeat (ticks) begin
         send_beat(ACTION_TICK, 15'($urandom));
         if (paced) pace_sender();
      end
   endtask

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : check_samples
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         samples_seen++;
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected beat %0d: envelope %0d wave %0d", samples_seen,
                        rsp_if.payload.envelope_sample, rsp_if.payload.wave_sample);
            end
         end else begin
            want = expected_samples.pop_front();
            if (rsp_if.payload.envelope_sample !== want.envelope_sample ||
                rsp_if.payload.wave_sample !== want.wave_sample) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("beat %0d: envelope exp %0d got %0d, wave exp %0d got %0d",
                           samples_seen, want.envelope_sample,
                           rsp_if.payload.envelope_sample, want.wave_sample,
                           rsp_if.payload.wave_sample);
               end
            end
         end
      end
   end

   // Receiver: a counted hold-off when requested, else a changing stall pattern.
   always @(posedge clock) begin : drive_receiver
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (drain_left == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 3));
            drain_left = $urandom_range(8, 80);
         end
         drain_left--;
         case (drain_mode)
            DRAIN_FREE:   rsp_if.ready <= 1'b1;
            DRAIN_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: rsp_if.ready <= ($urandom_range(0, 5) == 0);
            default:      rsp_if.ready <= (drain_left[1:0] != 2'd0);
         endcase
      end
   end

   // ---------------------------------------------------------------- tests

   // Defaults after reset: silent envelope, zero phase; the level is ignored on ticks.
   task automatic test_idle_after_reset();
      send_beat(ACTION_TICK, 15'h7fff);
      send_beat(ACTION_TICK, 15'h0000);
   endtask

   // Full and minimal start levels, no decay and full decay, depth extremes.
   task automatic test_envelope_limits();
      voice_settings_type s;
      wait_for_samples();
      s = '{phase_inc: '1, decay: '0, shape: SHAPE_SINE, fifth: 1'b0, depth: '1};
      apply_settings(s);
      send_beat(ACTION_NOTE_ON, 15'h7fff);
      send_beat(ACTION_TICK, 15'h0000);
      send_beat(ACTION_NOTE_ON, 15'h0001);
      send_beat(ACTION_TICK, 15'h7fff);
      wait_for_samples();
      s = '{phase_inc: 28'h1234567, decay: '1, shape: SHAPE_SAW, fifth: 1'b1, depth: '0};
      apply_settings(s);
      send_beat(ACTION_NOTE_ON, 15'h7fff);
      send_beat(ACTION_TICK, 15'h5555);
      // envelope has ended; the held square still bends the pitch
      send_beat(ACTION_TICK, 15'h2aaa);
      send_beat(ACTION_NOTE_ON, 15'h0000);
      send_beat(ACTION_TICK, 15'h0000);
   endtask

   // Each shape under strong bend, so the phase crosses quadrants and wraps.
   task automatic test_wave_shapes();
      voice_settings_type s;
      for (int k = 0; k < 4; k++) begin
         wait_for_samples();
         s.phase_inc = 28'h0c00_0000;
         s.decay = 31'h0010_0000;
         s.shape = wave_shape_type'(k);
         s.fifth = (s.shape == SHAPE_SINE || s.shape == SHAPE_SQUARE);
         s.depth = '1;
         apply_settings(s);
         send_beat(ACTION_NOTE_ON, 15'h7fff);
         send_beat(ACTION_TICK, 15'h0000);
         send_beat(ACTION_TICK, 15'h7fff);
         if (s.shape == SHAPE_TRIANGLE) begin
            send_beat(ACTION_TICK, 15'h1234);
         end
      end
   endtask

   // Writes to indexes past the last register must change nothing.
   task automatic test_unlisted_index();
      wait_for_samples();
      for (int k = CSR_PITCH_DEPTH + 1; k < (1 << CSR_IDX_W); k++) begin
         write_csr(CSR_IDX_W'(k), '1);
      end
      close_csr();
      send_beat(ACTION_TICK, 15'h0000);
   endtask

   // Phases of random settings; mostly whole notes, some loose beats.
   task automatic test_random_voices();
      int unsigned finish_at;
      int unsigned phase_end;
      finish_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < finish_at) begin
         wait_for_samples();
         apply_settings(random_settings());
         phase_end = beats_sent + $urandom_range(60, 90);
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 6) != 0) begin
               play_voice(1'b1);
            end else begin
               repeat ($urandom_range(1, 4)) begin
                  send_beat(1'($urandom_range(0, 1)), 15'($urandom));
                  pace_sender();
               end
            end
         end
      end
   endtask

   // Hold the receiver off while beats keep coming, so the input backs up.
   task automatic test_output_backpressure();
      wait_for_samples();
      apply_settings(random_settings());
      stall_request = 400;
      play_voice(1'b0);
      play_voice(1'b0);
      wait_for_samples();
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      stall_request = 0;
      stall_left = 0;
      drain_left = 0;
      drain_mode = DRAIN_FREE;
      burst_left = 0;
      beats_sent = 0;
      note_ons = 0;
      samples_seen = 0;
      settings_applied = 0;
      mismatches = 0;
      cfg_phase_inc = '0;
      cfg_decay = '0;
      cfg_shape = SHAPE_SINE;
      cfg_fifth = 1'b0;
      cfg_depth = 10'd512;
      env_level = '0;
      env_square = '0;
      main_phase = '0;
      fifth_phase = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_envelope_limits();
      test_wave_shapes();
      test_unlisted_index();
      test_random_voices();
      test_output_backpressure();
      wait_for_samples();

      $display("covered %0d request beats (%0d note-ons) over %0d register settings,",
               beats_sent, note_ons, settings_applied);
      $display("all shapes, fifth on and off, depth and decay extremes; %0d samples checked",
               samples_seen);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("drum_voice_oscillator: match");
      end else begin
         $display("drum_voice_oscillator: mismatch");
      end
      $finish;
   end

endmodule
